FILE: src/tga_isd_pkg.sv
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared result type, result kinds, error codes and parser phases.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_isd_pkg;

   localparam int SigLength    = 12;
   localparam int InfoLast     = 16;
   localparam int RawType      = 2;
   localparam int RleType      = 10;
   localparam int Depth24      = 24;
   localparam int Depth32      = 32;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SIGNATURE = 3'd1,
      ERR_INFO      = 3'd2,
      ERR_OVERRUN   = 3'd3,
      ERR_TRUNCATED = 3'd4
   } error_type;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_SIG      = 7'b0000010,
      PH_INFO     = 7'b0000100,
      PH_PIX      = 7'b0001000,
      PH_DONE     = 7'b0010000,
      PH_ERR      = 7'b0100000,
      PH_INFO_BAD = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_res;
      logic [31:0] pixel_index;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      error_type   error_code;
      logic        image_done;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/tga_isd_parser.sv
// ----------------------------------------------------------------------------
// TGA decoder byte parser
// Holds the parse state and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_isd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                first_byte,
   input  wire logic                final_byte,
   output logic                     res_valid,
   output tga_isd_pkg::rsp_type     res
);

   tga_isd_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic        compressed_ff, compressed_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        four_ff, four_in;
   logic [31:0] prem_ff, prem_in;
   logic [31:0] pemit_ff, pemit_in;
   logic [7:0]  pkrem_ff, pkrem_in;
   logic        pkrun_ff, pkrun_in;
   logic [23:0] color_ff, color_in;
   logic [1:0]  bip_ff, bip_in;

   always_comb begin
      logic        ok;
      logic [1:0]  last;
      logic [7:0]  count;
      logic        done;
      logic [7:0]  red;
      logic [7:0]  alpha;

      phase_in      = phase_ff;
      hpos_in       = hpos_ff;
      compressed_in = compressed_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      four_in       = four_ff;
      prem_in       = prem_ff;
      pemit_in      = pemit_ff;
      pkrem_in      = pkrem_ff;
      pkrun_in      = pkrun_ff;
      color_in      = color_ff;
      bip_in        = bip_ff;
      res_valid     = 1'b0;
      res           = '0;
      ok            = 1'b0;
      last          = 2'd2;
      count         = 8'd1;
      done          = 1'b0;
      red           = 8'd0;
      alpha         = 8'd0;

      if (accept) begin
         // restart discards all progress
         if (first_byte) begin
            phase_in      = tga_isd_pkg::PH_SIG;
            hpos_in       = 5'd0;
            compressed_in = 1'b0;
            width_in      = 16'd0;
            height_in     = 16'd0;
            four_in       = 1'b0;
            prem_in       = 32'd0;
            pemit_in      = 32'd0;
            pkrem_in      = 8'd0;
            pkrun_in      = 1'b0;
            color_in      = 24'd0;
            bip_in        = 2'd0;
         end

         case (phase_in)
            tga_isd_pkg::PH_SIG: begin
               if (hpos_in == 5'd2) begin
                  ok = data_byte inside {8'(tga_isd_pkg::RawType),
                                         8'(tga_isd_pkg::RleType)};
                  compressed_in = (data_byte == 8'(tga_isd_pkg::RleType));
               end else begin
                  ok = (data_byte == 8'd0);
               end
               if (!ok) begin
                  phase_in       = tga_isd_pkg::PH_ERR;
                  res_valid      = 1'b1;
                  res            = '0;
                  res.kind       = tga_isd_pkg::KIND_ERROR;
                  res.error_code = tga_isd_pkg::ERR_SIGNATURE;
               end else begin
                  hpos_in = hpos_in + 5'd1;
                  if (hpos_in >= 5'(tga_isd_pkg::SigLength)) begin
                     phase_in = tga_isd_pkg::PH_INFO;
                  end
               end
            end
            tga_isd_pkg::PH_INFO, tga_isd_pkg::PH_INFO_BAD: begin
               if (hpos_in > 5'(tga_isd_pkg::InfoLast)) begin
                  if (phase_in == tga_isd_pkg::PH_INFO_BAD || width_in == 16'd0 ||
                      height_in == 16'd0) begin
                     phase_in       = tga_isd_pkg::PH_ERR;
                     res_valid      = 1'b1;
                     res            = '0;
                     res.kind       = tga_isd_pkg::KIND_ERROR;
                     res.error_code = tga_isd_pkg::ERR_INFO;
                  end else begin
                     prem_in          = 32'(width_in) * 32'(height_in);
                     pemit_in         = 32'd0;
                     pkrem_in         = 8'd0;
                     bip_in           = 2'd0;
                     phase_in         = tga_isd_pkg::PH_PIX;
                     res_valid        = 1'b1;
                     res              = '0;
                     res.kind         = tga_isd_pkg::KIND_HEADER;
                     res.image_width  = width_in;
                     res.image_height = height_in;
                     res.has_alpha    = four_in;
                  end
               end else begin
                  case (hpos_in)
                     5'd12: width_in  = {8'd0, data_byte};
                     5'd13: width_in  = {data_byte, width_in[7:0]};
                     5'd14: height_in = {8'd0, data_byte};
                     5'd15: height_in = {data_byte, height_in[7:0]};
                     default: begin
                        if (data_byte == 8'(tga_isd_pkg::Depth32)) begin
                           four_in = 1'b1;
                        end else if (data_byte == 8'(tga_isd_pkg::Depth24)) begin
                           four_in = 1'b0;
                        end else begin
                           phase_in = tga_isd_pkg::PH_INFO_BAD;
                        end
                     end
                  endcase
                  hpos_in = hpos_in + 5'd1;
               end
            end
            tga_isd_pkg::PH_PIX: begin
               last = four_in ? 2'd3 : 2'd2;
               if (compressed_in && pkrem_in == 8'd0) begin
                  // packet header
                  if (!data_byte[7]) begin
                     pkrem_in = data_byte + 8'd1;
                     pkrun_in = 1'b0;
                  end else begin
                     pkrem_in = data_byte - 8'd127;
                     pkrun_in = 1'b1;
                  end
                  bip_in = 2'd0;
               end else if (bip_in < last) begin
                  case (bip_in)
                     2'd0:    color_in[7:0]   = data_byte;
                     2'd1:    color_in[15:8]  = data_byte;
                     default: color_in[23:16] = data_byte;
                  endcase
                  bip_in = bip_in + 2'd1;
               end else begin
                  bip_in = 2'd0;
                  red    = four_in ? color_in[23:16] : data_byte;
                  alpha  = four_in ? data_byte : 8'd0;
                  count  = (compressed_in && pkrun_in) ? pkrem_in : 8'd1;
                  if ({24'd0, count} > prem_in) begin
                     phase_in       = tga_isd_pkg::PH_ERR;
                     res_valid      = 1'b1;
                     res            = '0;
                     res.kind       = tga_isd_pkg::KIND_ERROR;
                     res.error_code = tga_isd_pkg::ERR_OVERRUN;
                  end else begin
                     if (compressed_in) begin
                        pkrem_in = pkrun_in ? 8'd0 : pkrem_in - 8'd1;
                     end
                     prem_in = prem_in - {24'd0, count};
                     done    = (prem_in == 32'd0) && (!compressed_in || pkrem_in == 8'd0);
                     res_valid        = 1'b1;
                     res.kind         = tga_isd_pkg::KIND_PIXEL;
                     res.red          = red;
                     res.green        = color_in[15:8];
                     res.blue         = color_in[7:0];
                     res.alpha        = alpha;
                     res.repeat_res   = count;
                     res.pixel_index  = pemit_in;
                     res.image_width  = width_in;
                     res.image_height = height_in;
                     res.has_alpha    = four_in;
                     res.error_code   = tga_isd_pkg::ERR_NONE;
                     res.image_done   = done;
                     pemit_in         = pemit_in + {24'd0, count};
                     if (done) begin
                        phase_in = tga_isd_pkg::PH_DONE;
                     end
                  end
               end
            end
            default: begin
            end
         endcase

         // truncation replaces whatever this byte produced
         if (final_byte && (phase_in inside {tga_isd_pkg::PH_SIG, tga_isd_pkg::PH_INFO,
                                             tga_isd_pkg::PH_INFO_BAD, tga_isd_pkg::PH_PIX})) begin
            phase_in       = tga_isd_pkg::PH_ERR;
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = tga_isd_pkg::KIND_ERROR;
            res.error_code = tga_isd_pkg::ERR_TRUNCATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tga_isd_pkg::PH_IDLE;
         hpos_ff       <= 5'd0;
         compressed_ff <= 1'b0;
         width_ff      <= 16'd0;
         height_ff     <= 16'd0;
         four_ff       <= 1'b0;
         prem_ff       <= 32'd0;
         pemit_ff      <= 32'd0;
         pkrem_ff      <= 8'd0;
         pkrun_ff      <= 1'b0;
         color_ff      <= 24'd0;
         bip_ff        <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         hpos_ff       <= hpos_in;
         compressed_ff <= compressed_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         four_ff       <= four_in;
         prem_ff       <= prem_in;
         pemit_ff      <= pemit_in;
         pkrem_ff      <= pkrem_in;
         pkrun_ff      <= pkrun_in;
         color_ff      <= color_in;
         bip_ff        <= bip_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/tga_isd_rsp_buf.sv
// ----------------------------------------------------------------------------
// TGA decoder result buffer
// Output register plus one skid entry; stall upstream only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_isd_rsp_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tga_isd_pkg::rsp_type push_data,
   output logic                      full,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output tga_isd_pkg::rsp_type      out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   tga_isd_pkg::rsp_type out_ff, out_in;
   tga_isd_pkg::rsp_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !out_stall) begin
         // output slot frees up: advance skid first, else take the new beat
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

FILE: src/tga_image_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// TGA image stream decoder
// Parses a raw or RLE true-color Targa file one byte per beat and emits
// header, pixel/run and error results.
// ----------------------------------------------------------------------------
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | data_byte, first_byte, final_byte
//   rsp     | out       | rsp_valid/stall   | kind, color, repeat, index, header, error
//
// One byte is taken every cycle unless req_stall is high; its result, if any,
// goes from the single parser step into the output register or its skid entry.
// Reset is synchronous and returns the parser to idle with no results held.
// req_stall rises only when the output register and its skid entry both hold
// results that rsp has not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_image_stream_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic [7:0]       rsp_repeat_res,
   output logic [31:0]      rsp_pixel_index,
   output logic [15:0]      rsp_image_width,
   output logic [15:0]      rsp_image_height,
   output logic             rsp_has_alpha,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_image_done
);

   logic                 accept;
   logic                 res_valid;
   logic                 buf_full;
   tga_isd_pkg::rsp_type res;
   tga_isd_pkg::rsp_type out_data;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   tga_isd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .final_byte (req_final_byte),
      .res_valid  (res_valid),
      .res        (res)
   );

   tga_isd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_red          = out_data.red;
   assign rsp_green        = out_data.green;
   assign rsp_blue         = out_data.blue;
   assign rsp_alpha        = out_data.alpha;
   assign rsp_repeat_res   = out_data.repeat_res;
   assign rsp_pixel_index  = out_data.pixel_index;
   assign rsp_image_width  = out_data.image_width;
   assign rsp_image_height = out_data.image_height;
   assign rsp_has_alpha    = out_data.has_alpha;
   assign rsp_error_code   = out_data.error_code;
   assign rsp_image_done   = out_data.image_done;

endmodule

`default_nettype wire

FILE: test/tb_tga_image_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// TGA image stream decoder testbench
// Feeds raw and RLE Targa files, some well formed and some broken, one byte
// per beat, predicts every header, pixel and error result with a parser of
// its own and checks the result channel field by field under random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tga_image_stream_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 8;
   localparam int IdlePct = 35;

   typedef struct {
      logic [7:0] data;
      logic       sof;
      logic       eof;
      bit         hold;
   } file_beat_type;

   typedef enum int {
      FLAW_NONE,
      FLAW_SIG,
      FLAW_DEPTH,
      FLAW_ZERO,
      FLAW_OVERRUN,
      FLAW_CUT,
      FLAW_RESTART,
      FLAW_NOISE
   } flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_res;
   logic [31:0] rsp_pixel_index;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic        rsp_has_alpha;
   logic [2:0]  rsp_error_code;
   logic        rsp_image_done;

   file_beat_type        file_bytes_q[$];
   tga_isd_pkg::rsp_type decoded_q[$];
   file_beat_type        cur_beat;
   bit          quiet = 1'b0;
   bit          pause_placed = 1'b0;
   int          beats_total = 0;
   int          beats_sent = 0;
   int          beats_taken = 0;
   int          mismatches = 0;
   int          cycles = 0;

   // parser state of the prediction
   tga_isd_pkg::phase_type st_phase = tga_isd_pkg::PH_IDLE;
   logic [4:0]  st_pos = '0;
   logic        st_rle = 1'b0;
   logic [15:0] st_width = '0;
   logic [15:0] st_height = '0;
   logic        st_four = 1'b0;
   logic [31:0] st_left = '0;
   logic [31:0] st_emitted = '0;
   logic [7:0]  st_packet = '0;
   logic        st_run = 1'b0;
   logic [23:0] st_color = '0;
   logic [1:0]  st_byte_pos = '0;

   tga_image_stream_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_repeat_res  (rsp_repeat_res),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_image_width (rsp_image_width),
      .rsp_image_height(rsp_image_height),
      .rsp_has_alpha   (rsp_has_alpha),
      .rsp_error_code  (rsp_error_code),
      .rsp_image_done  (rsp_image_done)
   );

   always #1 clock = ~clock;

   function automatic tga_isd_pkg::rsp_type tga_fault(tga_isd_pkg::error_type code);
      tga_isd_pkg::rsp_type r;
      r = '0;
      r.kind = tga_isd_pkg::KIND_ERROR;
      r.error_code = code;
      st_phase = tga_isd_pkg::PH_ERR;
      return r;
   endfunction

   function automatic tga_isd_pkg::rsp_type held_info(tga_isd_pkg::kind_type k);
      tga_isd_pkg::rsp_type r;
      r = '0;
      r.kind = k;
      r.image_width = st_width;
      r.image_height = st_height;
      r.has_alpha = st_four;
      r.error_code = tga_isd_pkg::ERR_NONE;
      return r;
   endfunction

   task automatic tga_parse_byte(input file_beat_type beat);
      logic [7:0]  b;
      logic [1:0]  last;
      logic [31:0] count;
      tga_isd_pkg::rsp_type r;
      bit          got;
      bit          good;
      bit          done;
      b = beat.data;
      got = 1'b0;
      r = '0;
      // start of file: drop all progress
      if (beat.sof) begin
         st_pos = '0;
         st_rle = 1'b0;
         st_width = '0;
         st_height = '0;
         st_four = 1'b0;
         st_left = '0;
         st_emitted = '0;
         st_packet = '0;
         st_run = 1'b0;
         st_color = '0;
         st_byte_pos = '0;
         st_phase = tga_isd_pkg::PH_SIG;
      end
      case (st_phase)
         tga_isd_pkg::PH_SIG: begin
            good = (st_pos == 2) ?
                   (b == tga_isd_pkg::RawType || b == tga_isd_pkg::RleType) : (b == 0);
            if (st_pos == 2) st_rle = (b == tga_isd_pkg::RleType);
            if (!good) begin
               r = tga_fault(tga_isd_pkg::ERR_SIGNATURE);
               got = 1'b1;
            end else begin
               st_pos++;
               if (st_pos >= tga_isd_pkg::SigLength) st_phase = tga_isd_pkg::PH_INFO;
            end
         end
         tga_isd_pkg::PH_INFO, tga_isd_pkg::PH_INFO_BAD: begin
            case (st_pos)
               tga_isd_pkg::SigLength:     st_width = {8'h00, b};
               tga_isd_pkg::SigLength + 1: st_width[15:8] = b;
               tga_isd_pkg::SigLength + 2: st_height = {8'h00, b};
               tga_isd_pkg::SigLength + 3: st_height[15:8] = b;
               tga_isd_pkg::InfoLast: begin
                  if (b == tga_isd_pkg::Depth32) st_four = 1'b1;
                  else if (b == tga_isd_pkg::Depth24) st_four = 1'b0;
                  else st_phase = tga_isd_pkg::PH_INFO_BAD;
               end
               default: begin
                  // descriptor byte closes the info header
                  if (st_phase == tga_isd_pkg::PH_INFO_BAD || st_width == 0 ||
                      st_height == 0) begin
                     r = tga_fault(tga_isd_pkg::ERR_INFO);
                  end else begin
                     st_left = 32'(st_width) * 32'(st_height);
                     st_emitted = '0;
                     st_packet = '0;
                     st_byte_pos = '0;
                     st_phase = tga_isd_pkg::PH_PIX;
                     r = held_info(tga_isd_pkg::KIND_HEADER);
                  end
                  got = 1'b1;
               end
            endcase
            if (!got) st_pos++;
         end
         tga_isd_pkg::PH_PIX: begin
            last = st_four ? 2'd3 : 2'd2;
            if (st_rle && st_packet == 0) begin
               if (!b[7]) begin
                  st_packet = b + 8'd1;
                  st_run = 1'b0;
               end else begin
                  st_packet = b - 8'd127;
                  st_run = 1'b1;
               end
               st_byte_pos = '0;
            end else if (st_byte_pos < last) begin
               st_color[8*st_byte_pos +: 8] = b;
               st_byte_pos++;
            end else begin
               st_byte_pos = '0;
               count = (st_rle && st_run) ? 32'(st_packet) : 32'd1;
               if (count > st_left) begin
                  r = tga_fault(tga_isd_pkg::ERR_OVERRUN);
               end else begin
                  if (st_rle) begin
                     if (st_run) st_packet = '0;
                     else st_packet--;
                  end
                  st_left -= count;
                  done = (st_left == 0) && (!st_rle || st_packet == 0);
                  r = held_info(tga_isd_pkg::KIND_PIXEL);
                  r.red = st_four ? st_color[23:16] : b;
                  r.green = st_color[15:8];
                  r.blue = st_color[7:0];
                  r.alpha = st_four ? b : 8'h00;
                  r.repeat_res = count[7:0];
                  r.pixel_index = st_emitted;
                  r.image_done = done;
                  st_emitted += count;
                  if (done) st_phase = tga_isd_pkg::PH_DONE;
               end
               got = 1'b1;
            end
         end
         default: ;
      endcase
      // last byte of an unfinished image overrides the beat's own result
      if (beat.eof && (st_phase == tga_isd_pkg::PH_SIG || st_phase == tga_isd_pkg::PH_INFO ||
                       st_phase == tga_isd_pkg::PH_INFO_BAD ||
                       st_phase == tga_isd_pkg::PH_PIX)) begin
         r = tga_fault(tga_isd_pkg::ERR_TRUNCATED);
         got = 1'b1;
      end
      if (got) decoded_q.push_back(r);
   endtask

   task automatic push_beat(input logic [7:0] data, input logic sof, input logic eof);
      file_beat_type beat;
      beat.data = data;
      beat.sof = sof;
      beat.eof = eof;
      // once, midway, hold the next file until the decoder has drained
      beat.hold = sof && !pause_placed && file_bytes_q.size() >= 250;
      if (beat.hold) pause_placed = 1'b1;
      file_bytes_q.push_back(beat);
   endtask

   task automatic build_file(input bit rle, input bit four, input logic [15:0] w,
                             input logic [15:0] h, input flaw_type flaw);
      logic [7:0]  fb[$];
      logic [7:0]  depth;
      int unsigned left;
      int unsigned top;
      int unsigned cnt;
      int          extra;
      int          bpp;
      int          n;
      int          j;
      bit          give_final;
      bpp = four ? 4 : 3;
      for (j = 0; j < tga_isd_pkg::SigLength; j++) fb.push_back(8'h00);
      fb[2] = rle ? 8'(tga_isd_pkg::RleType) : 8'(tga_isd_pkg::RawType);
      if (flaw == FLAW_SIG) begin
         j = $urandom_range(tga_isd_pkg::SigLength - 1);
         if (j == 2) begin
            do fb[2] = 8'($urandom_range(255));
            while (fb[2] == tga_isd_pkg::RawType || fb[2] == tga_isd_pkg::RleType);
         end else begin
            fb[j] = 8'($urandom_range(1, 255));
         end
      end
      depth = four ? 8'(tga_isd_pkg::Depth32) : 8'(tga_isd_pkg::Depth24);
      if (flaw == FLAW_DEPTH) depth = 8'($urandom_range(255));
      if (flaw == FLAW_ZERO) begin
         if ($urandom_range(1)) w = '0;
         else h = '0;
      end
      fb.push_back(w[7:0]);
      fb.push_back(w[15:8]);
      fb.push_back(h[7:0]);
      fb.push_back(h[15:8]);
      fb.push_back(depth);
      fb.push_back(8'($urandom_range(255)));
      left = w;
      left = left * h;
      // large images stop early and end up truncated
      while (left > 0 && fb.size() < 90) begin
         if (rle) begin
            top = (left < 128) ? left : 128;
            if ($urandom_range(1)) begin
               cnt = $urandom_range(1, top);
               extra = (flaw == FLAW_OVERRUN && cnt == left && cnt < 128) ? 1 : 0;
               fb.push_back(8'(127 + cnt + extra));
               for (j = 0; j < bpp; j++) fb.push_back(8'($urandom_range(255)));
            end else begin
               if (top > 6) top = 6;
               cnt = $urandom_range(1, top);
               extra = (flaw == FLAW_OVERRUN && cnt == left) ? 1 : 0;
               fb.push_back(8'(cnt + extra - 1));
               for (j = 0; j < bpp * (cnt + extra); j++)
                  fb.push_back(8'($urandom_range(255)));
            end
         end else begin
            cnt = 1;
            for (j = 0; j < bpp; j++) fb.push_back(8'($urandom_range(255)));
         end
         left -= cnt;
      end
      n = fb.size();
      if (flaw == FLAW_CUT || flaw == FLAW_RESTART) n = $urandom_range(1, n - 1);
      give_final = (flaw != FLAW_RESTART) && ($urandom_range(3) != 0 || flaw == FLAW_CUT);
      for (j = 0; j < n; j++) push_beat(fb[j], j == 0, (j == n - 1) && give_final);
      // stray bytes after a file are ignored unless the file was left unfinished
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(1, 3)) push_beat(8'($urandom_range(255)), 1'b0,
                                                 1'($urandom_range(1)));
      end
   endtask

   task automatic build_stimulus();
      int       pick;
      int       j;
      flaw_type flaw;
      bit       rle;
      logic [15:0] w;
      logic [15:0] h;
      // bytes before any file are ignored
      push_beat(8'hFF, 1'b0, 1'b1);
      push_beat(8'h00, 1'b0, 1'b0);
      // bad signature at the first byte, then a bad image type
      push_beat(8'h01, 1'b1, 1'b0);
      push_beat(8'h00, 1'b1, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'h03, 1'b0, 1'b0);
      // raw 32-bit 1x1 image with extreme channel values
      for (j = 0; j < tga_isd_pkg::SigLength; j++)
         push_beat((j == 2) ? 8'(tga_isd_pkg::RawType) : 8'h00, j == 0, 1'b0);
      push_beat(8'h01, 1'b0, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'h01, 1'b0, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'(tga_isd_pkg::Depth32), 1'b0, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b1);
      push_beat(8'hAA, 1'b0, 1'b1);

      while (file_bytes_q.size() < 470) begin
         pick = $urandom_range(99);
         if (pick < 55) flaw = FLAW_NONE;
         else if (pick < 62) flaw = FLAW_SIG;
         else if (pick < 68) flaw = FLAW_DEPTH;
         else if (pick < 73) flaw = FLAW_ZERO;
         else if (pick < 83) flaw = FLAW_OVERRUN;
         else if (pick < 91) flaw = FLAW_CUT;
         else if (pick < 96) flaw = FLAW_RESTART;
         else flaw = FLAW_NOISE;
         if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 6))
               push_beat(8'($urandom_range(255)), $urandom_range(3) == 0,
                         $urandom_range(3) == 0);
         end else begin
            pick = $urandom_range(99);
            if (pick < 85) begin
               w = 16'($urandom_range(1, 5));
               h = 16'($urandom_range(1, 4));
            end else if (pick < 95) begin
               w = 16'($urandom_range(1, 65535));
               h = 16'($urandom_range(1, 65535));
            end else begin
               w = 16'hFFFF;
               h = $urandom_range(1) ? 16'hFFFF : 16'h0001;
            end
            rle = (flaw == FLAW_OVERRUN) ? 1'b1 : 1'($urandom_range(1));
            build_file(rle, 1'($urandom_range(1)), w, h, flaw);
         end
      end
   endtask

   // beat acceptance and prediction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         tga_parse_byte(cur_beat);
         beats_taken++;
         quiet = (beats_taken >= 150 && beats_taken < 300);
      end
   end

   // request driver and result-side stall
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (!reset) begin
         // drop the beat once the decoder has taken it
         if (beats_taken == beats_sent) next_valid = 1'b0;
         if (!next_valid && file_bytes_q.size() > 0 &&
             !(file_bytes_q[0].hold && decoded_q.size() > 0) &&
             (quiet || $urandom_range(99) >= IdlePct)) begin
            cur_beat = file_bytes_q.pop_front();
            req_data_byte <= cur_beat.data;
            req_first_byte <= cur_beat.sof;
            req_final_byte <= cur_beat.eof;
            beats_sent++;
            next_valid = 1'b1;
         end
         rsp_stall <= !quiet && ($urandom_range(99) < IdlePct);
      end
      req_valid <= next_valid;
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result monitor and run limit
   always @(posedge clock) begin
      tga_isd_pkg::rsp_type want;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $display("%0t ns: result beat with nothing outstanding, kind %0d",
                     $time, rsp_kind);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("alpha", want.alpha, rsp_alpha);
            check_field("repeat_res", want.repeat_res, rsp_repeat_res);
            check_field("pixel_index", want.pixel_index, rsp_pixel_index);
            check_field("image_width", want.image_width, rsp_image_width);
            check_field("image_height", want.image_height, rsp_image_height);
            check_field("has_alpha", want.has_alpha, rsp_has_alpha);
            check_field("error_code", want.error_code, rsp_error_code);
            check_field("image_done", want.image_done, rsp_image_done);
         end
      end
   end

   initial begin
      build_stimulus();
      beats_total = file_bytes_q.size();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      while (beats_taken < beats_total || decoded_q.size() > 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (decoded_q.size() != 0) begin
         $display("%0t ns: %0d results never arrived", $time, decoded_q.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
